[rtl/core/sfp_pkg.sv]
// Shared widths, limits and status codes for the four-point sphere fit.
// No dependencies; every file of the sphere fit imports this package.
`timescale 1ns / 1ps

package sfp_pkg;

  // Coordinate and register widths.
  localparam int CW   = 32;             // coordinate bits (signed fixed point)
  localparam int MPDW = 31;             // min pair distance register bits
  localparam int TSW  = 2 * MPDW;       // squared threshold

  // Difference rows, products and cofactors.
  localparam int DW   = CW + 1;         // coordinate difference
  localparam int PW   = 2 * DW;         // product of two differences
  localparam int HW   = PW;             // half-squared-norm term (unsigned)
  localparam int CFW  = PW + 1;         // 2x2 cofactor (signed)
  localparam int LW   = DW;             // low limb of a split operand
  localparam int MW   = 2 * (LW + 1);   // limb partial product (signed)
  localparam int DETW = DW + CFW + 1;   // 3x3 determinant (signed)
  localparam int NW   = HW + CFW + 3;   // Cramer numerator (signed)

  // Divider.
  localparam int DENW = DETW;           // doubled determinant magnitude
  localparam int QW   = CW + 3;         // quotient bits kept before overflow
  localparam int RW   = DENW + QW;      // partial remainder

  // Centre and radius.
  localparam int CXW  = QW + 3;         // centre sum before saturation
  localparam int SW   = 2 * CW + 2;     // squared radius
  localparam int RTW  = CW + 1;         // integer root bits
  localparam int SRW  = RTW + 3;        // root partial remainder

  // Pipeline depth from the input register to the output register.
  localparam int LAT  = 12 + QW + RTW;

  localparam logic signed [CXW-1:0] CEN_MAX = CXW'((longint'(1) << (CW - 1)) - 1);
  localparam logic signed [CXW-1:0] CEN_MIN = -CEN_MAX - CXW'(1);

  typedef enum logic [1:0] {
    FIT_OK        = 2'd0,
    FIT_COPLANAR  = 2'd1,
    FIT_TOO_CLOSE = 2'd2,
    FIT_SATURATED = 2'd3
  } fit_status_t;

  // Fields that ride alongside the three divisions.
  typedef struct packed {
    logic [2:0][CW-1:0] p0;
    logic               copl;
    logic               close;
    logic [2:0]         nsg;
    logic [2:0]         ovf;
    logic [DENW-1:0]    den;
  } div_side_t;

  // Fields that ride alongside the square root.
  typedef struct packed {
    logic [2:0][CW-1:0] center;
    logic               copl;
    logic               close;
    logic               csat;
    logic               radsat;
    logic [SW-1:0]      sum;
  } root_side_t;

endpackage

[rtl/core/sphere_from_four_points.sv]
// Sphere through four 3-D points: difference rows, Cramer's rule, pipelined
// division and square root, all in one pipeline. Depends on sfp_pkg.
`timescale 1ns / 1ps
//
//  channel   signals                                    moves
//  input     in_valid, in_ready, point_{a,b,c,d}_{x,y,z}  one point quadruple
//  result    out_valid, out_ready, center_{x,y,z},      one sphere fit
//            radius, fit_status
//  config    cfg_valid, cfg_ready, min_pair_distance    one register write
//
//  The pipeline is LAT = 80 registers deep; one request enters per cycle
//  while no result waits on out_ready.
//  The depth comes from the 35 quotient-bit stages of the three
//  parallel dividers and the 33 root-bit stages of the square root.
//  Reset clears the valid bits and the distance register; the pipeline is
//  ready the cycle after reset. When a result waits on out_ready, every stage
//  holds and in_ready drops, so nothing is lost or repeated.

module sphere_from_four_points
  import sfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] point_a_x,
  input  logic signed [CW-1:0] point_a_y,
  input  logic signed [CW-1:0] point_a_z,
  input  logic signed [CW-1:0] point_b_x,
  input  logic signed [CW-1:0] point_b_y,
  input  logic signed [CW-1:0] point_b_z,
  input  logic signed [CW-1:0] point_c_x,
  input  logic signed [CW-1:0] point_c_y,
  input  logic signed [CW-1:0] point_c_z,
  input  logic signed [CW-1:0] point_d_x,
  input  logic signed [CW-1:0] point_d_y,
  input  logic signed [CW-1:0] point_d_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW-1:0] center_x,
  output logic signed [CW-1:0] center_y,
  output logic signed [CW-1:0] center_z,
  output logic        [CW-1:0] radius,
  output logic        [1:0]    fit_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [MPDW-1:0]      min_pair_distance
);

  localparam int PAIR_A [3] = '{1, 1, 2};
  localparam int PAIR_B [3] = '{2, 3, 3};

  logic            adv;
  logic [LAT-1:0]  vld;
  logic [MPDW-1:0] min_dist;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= '0;
    end else if (cfg_valid) begin
      min_dist <= min_pair_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [CW-1:0] pt [4][3];
  assign pt[0][0] = point_a_x;
  assign pt[0][1] = point_a_y;
  assign pt[0][2] = point_a_z;
  assign pt[1][0] = point_b_x;
  assign pt[1][1] = point_b_y;
  assign pt[1][2] = point_b_z;
  assign pt[2][0] = point_c_x;
  assign pt[2][1] = point_c_y;
  assign pt[2][2] = point_c_z;
  assign pt[3][0] = point_d_x;
  assign pt[3][1] = point_d_y;
  assign pt[3][2] = point_d_z;

  // Stage 1: difference rows against point a, and the other three pairs.
  logic signed [DW-1:0] s1_m [3][3];
  logic signed [DW-1:0] s1_e [3][3];
  logic [2:0][CW-1:0]   s1_p0;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_p0[i] <= pt[0][i];
        for (int j = 0; j < 3; j++) begin
          s1_m[i][j] <= DW'(pt[i+1][j]) - DW'(pt[0][j]);
          s1_e[i][j] <= DW'(pt[PAIR_A[i]][j]) - DW'(pt[PAIR_B[i]][j]);
        end
      end
    end
  end

  // Stage 2: squares and the products that form the signed 2x2 cofactors.
  logic signed [PW-1:0] s2_pa_d [3][3];
  logic signed [PW-1:0] s2_pb_d [3][3];

  for (genvar gi = 0; gi < 3; gi++) begin : g_cof_row
    for (genvar gk = 0; gk < 3; gk++) begin : g_cof_col
      localparam int R0 = (gi == 0) ? 1 : 0;
      localparam int R1 = (gi == 2) ? 1 : 2;
      localparam int C0 = (gk == 0) ? 1 : 0;
      localparam int C1 = (gk == 2) ? 1 : 2;
      localparam int ODD = (gi + gk) % 2;
      if (ODD == 0) begin : g_even
        assign s2_pa_d[gi][gk] = s1_m[R0][C0] * s1_m[R1][C1];
        assign s2_pb_d[gi][gk] = s1_m[R0][C1] * s1_m[R1][C0];
      end else begin : g_odd
        assign s2_pa_d[gi][gk] = s1_m[R0][C1] * s1_m[R1][C0];
        assign s2_pb_d[gi][gk] = s1_m[R0][C0] * s1_m[R1][C1];
      end
    end
  end

  logic [PW-1:0]        s2_hsq [3][3];
  logic [PW-1:0]        s2_esq [3][3];
  logic signed [PW-1:0] s2_pa [3][3];
  logic signed [PW-1:0] s2_pb [3][3];
  logic [TSW-1:0]       s2_tsq;
  logic signed [DW-1:0] s2_m [3][3];
  logic [2:0][CW-1:0]   s2_p0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tsq <= TSW'(min_dist) * TSW'(min_dist);
      s2_p0  <= s1_p0;
      s2_m   <= s1_m;
      s2_pa  <= s2_pa_d;
      s2_pb  <= s2_pb_d;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s2_hsq[i][j] <= s1_m[i][j] * s1_m[i][j];
          s2_esq[i][j] <= s1_e[i][j] * s1_e[i][j];
        end
      end
    end
  end

  // Stage 3: half-squared-norm terms, pair distances, cofactors.
  logic [HW-1:0] s3_h_d [3];
  logic [HW-1:0] s3_g_d [3];
  logic          s3_close_d;

  always_comb begin
    s3_close_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s3_h_d[i] = s2_hsq[i][0] + s2_hsq[i][1] + s2_hsq[i][2];
      s3_g_d[i] = s2_esq[i][0] + s2_esq[i][1] + s2_esq[i][2];
      if (s3_h_d[i] < HW'(s2_tsq) || s3_g_d[i] < HW'(s2_tsq)) begin
        s3_close_d = 1'b1;
      end
    end
  end

  logic [HW-1:0]         s3_h [3];
  logic signed [CFW-1:0] s3_cof [3][3];
  logic                  s3_close;
  logic signed [DW-1:0]  s3_m [3];
  logic [2:0][CW-1:0]    s3_p0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_h     <= s3_h_d;
      s3_close <= s3_close_d;
      s3_p0    <= s2_p0;
      s3_m     <= s2_m[0];
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s3_cof[i][k] <= CFW'(s2_pa[i][k]) - CFW'(s2_pb[i][k]);
        end
      end
    end
  end

  // Stage 4: limb partial products. The determinant expands along row 0,
  // each numerator along the column that the h terms replace.
  logic signed [LW:0] c_lo [3][3];
  logic signed [LW:0] c_hi [3][3];
  logic signed [LW:0] h_lo [3];
  logic signed [LW:0] h_hi [3];
  logic signed [LW:0] m_ex [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_lo[i] = $signed({1'b0, s3_h[i][LW-1:0]});
      h_hi[i] = $signed({1'b0, s3_h[i][HW-1:LW]});
      m_ex[i] = (LW+1)'(s3_m[i]);
      for (int k = 0; k < 3; k++) begin
        c_lo[i][k] = $signed({1'b0, s3_cof[i][k][LW-1:0]});
        c_hi[i][k] = s3_cof[i][k][CFW-1:LW];
      end
    end
  end

  logic signed [MW-1:0] s4_dl [3];
  logic signed [MW-1:0] s4_dh [3];
  logic signed [MW-1:0] s4_nll [3][3];
  logic signed [MW-1:0] s4_nlh [3][3];
  logic signed [MW-1:0] s4_nhl [3][3];
  logic signed [MW-1:0] s4_nhh [3][3];
  logic                 s4_close;
  logic [2:0][CW-1:0]   s4_p0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_close <= s3_close;
      s4_p0    <= s3_p0;
      for (int j = 0; j < 3; j++) begin
        s4_dl[j] <= m_ex[j] * c_lo[0][j];
        s4_dh[j] <= m_ex[j] * c_hi[0][j];
      end
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          s4_nll[k][i] <= h_lo[i] * c_lo[i][k];
          s4_nlh[k][i] <= h_lo[i] * c_hi[i][k];
          s4_nhl[k][i] <= h_hi[i] * c_lo[i][k];
          s4_nhh[k][i] <= h_hi[i] * c_hi[i][k];
        end
      end
    end
  end

  // Stage 5: recombine limbs into full terms.
  logic signed [DETW-1:0] s5_dt [3];
  logic signed [NW-1:0]   s5_nt [3][3];
  logic                   s5_close;
  logic [2:0][CW-1:0]     s5_p0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_close <= s4_close;
      s5_p0    <= s4_p0;
      for (int j = 0; j < 3; j++) begin
        s5_dt[j] <= DETW'(s4_dl[j]) + (DETW'(s4_dh[j]) <<< LW);
      end
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          s5_nt[k][i] <= (NW'(s4_nhh[k][i]) <<< (2 * LW))
                       + ((NW'(s4_nlh[k][i]) + NW'(s4_nhl[k][i])) <<< LW)
                       + NW'(s4_nll[k][i]);
        end
      end
    end
  end

  // Stage 6: determinant and the three Cramer numerators.
  logic signed [DETW-1:0] s6_det;
  logic signed [NW-1:0]   s6_n [3];
  logic                   s6_close;
  logic [2:0][CW-1:0]     s6_p0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_close <= s5_close;
      s6_p0    <= s5_p0;
      s6_det   <= s5_dt[0] + s5_dt[1] + s5_dt[2];
      for (int k = 0; k < 3; k++) begin
        s6_n[k] <= s5_nt[k][0] + s5_nt[k][1] + s5_nt[k][2];
      end
    end
  end

  // Stage 7: magnitudes and signs. The 0.5 of the scheme doubles the divisor.
  logic [DETW-1:0] abs_det;
  assign abs_det = s6_det[DETW-1] ? DETW'(-s6_det) : DETW'(s6_det);

  logic [NW-1:0]      s7_nmag [3];
  logic [2:0]         s7_nsg;
  logic [DENW-1:0]    s7_den;
  logic               s7_copl;
  logic               s7_close;
  logic [2:0][CW-1:0] s7_p0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_copl  <= (s6_det == '0);
      s7_close <= s6_close;
      s7_p0    <= s6_p0;
      s7_den   <= {abs_det[DENW-2:0], 1'b0};
      for (int k = 0; k < 3; k++) begin
        s7_nmag[k] <= s6_n[k][NW-1] ? NW'(-s6_n[k]) : NW'(s6_n[k]);
        s7_nsg[k]  <= s6_n[k][NW-1] ^ s6_det[DETW-1];
      end
    end
  end

  // Stage 8 loads the dividers; each following stage settles one quotient bit.
  logic [RW-1:0] dv_rem [0:QW][3];
  logic [QW-1:0] dv_q   [0:QW][3];
  div_side_t     dv_side [0:QW];

  logic [RW-1:0] dv_rem_n [0:QW-1][3];
  logic [QW-1:0] dv_q_n   [0:QW-1][3];
  logic          dv_ge    [0:QW-1][3];

  for (genvar gs = 0; gs < QW; gs++) begin : g_div
    localparam int BIT = QW - 1 - gs;
    for (genvar gk = 0; gk < 3; gk++) begin : g_lane
      assign dv_ge[gs][gk]    = dv_rem[gs][gk] >= (RW'(dv_side[gs].den) << BIT);
      assign dv_rem_n[gs][gk] = dv_ge[gs][gk]
                              ? dv_rem[gs][gk] - (RW'(dv_side[gs].den) << BIT)
                              : dv_rem[gs][gk];
      assign dv_q_n[gs][gk]   = dv_q[gs][gk] | (QW'(dv_ge[gs][gk]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0].p0    <= s7_p0;
      dv_side[0].copl  <= s7_copl;
      dv_side[0].close <= s7_close;
      dv_side[0].nsg   <= s7_nsg;
      dv_side[0].den   <= s7_den;
      for (int k = 0; k < 3; k++) begin
        // A quotient of 2^QW or more saturates that centre coordinate and the radius.
        dv_side[0].ovf[k] <= RW'(s7_nmag[k]) >= (RW'(s7_den) << QW);
        dv_rem[0][k]      <= RW'(s7_nmag[k]);
        dv_q[0][k]        <= '0;
      end
      for (int s = 0; s < QW; s++) begin
        dv_rem[s+1]  <= dv_rem_n[s];
        dv_q[s+1]    <= dv_q_n[s];
        dv_side[s+1] <= dv_side[s];
      end
    end
  end

  // R1: round to nearest, ties away from zero (sign applied later).
  logic [QW:0] r1_qm [3];
  div_side_t   r1_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_side <= dv_side[QW];
      for (int k = 0; k < 3; k++) begin
        r1_qm[k] <= {1'b0, dv_q[QW][k]}
                  + (QW+1)'({dv_rem[QW][k], 1'b0} >= {1'b0, RW'(dv_side[QW].den)});
      end
    end
  end

  // R2: centre with saturation, squared offsets for the radius.
  logic signed [CXW-1:0] cq [3];
  logic signed [CXW-1:0] cx [3];
  logic [CW-1:0]         cen_d [3];
  logic                  csat_d;
  logic                  radsat_d;

  always_comb begin
    csat_d   = 1'b0;
    radsat_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      cq[k] = CXW'(r1_qm[k]);
      cx[k] = CXW'($signed(r1_side.p0[k])) + (r1_side.nsg[k] ? -cq[k] : cq[k]);
      if (r1_side.ovf[k]) begin
        cen_d[k] = r1_side.nsg[k] ? CEN_MIN[CW-1:0] : CEN_MAX[CW-1:0];
        csat_d   = 1'b1;
      end else if (cx[k] > CEN_MAX) begin
        cen_d[k] = CEN_MAX[CW-1:0];
        csat_d   = 1'b1;
      end else if (cx[k] < CEN_MIN) begin
        cen_d[k] = CEN_MIN[CW-1:0];
        csat_d   = 1'b1;
      end else begin
        cen_d[k] = cx[k][CW-1:0];
      end
      if (r1_side.ovf[k] || (r1_qm[k][QW:CW] != '0)) begin
        radsat_d = 1'b1;
      end
    end
  end

  logic [2*CW-1:0]    r2_sq [3];
  logic [2:0][CW-1:0] r2_center;
  logic               r2_copl;
  logic               r2_close;
  logic               r2_csat;
  logic               r2_radsat;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_copl   <= r1_side.copl;
      r2_close  <= r1_side.close;
      r2_csat   <= csat_d;
      r2_radsat <= radsat_d;
      for (int k = 0; k < 3; k++) begin
        r2_center[k] <= cen_d[k];
        r2_sq[k]     <= r1_qm[k][CW-1:0] * r1_qm[k][CW-1:0];
      end
    end
  end

  // R3 sums the squares and loads the root; each following stage settles
  // one root bit from two radicand bits.
  logic [SRW-1:0] sq_rem  [0:RTW];
  logic [RTW-1:0] sq_root [0:RTW];
  root_side_t     sq_side [0:RTW];

  logic [SRW-1:0] sq_acc    [0:RTW-1];
  logic [SRW-1:0] sq_trial  [0:RTW-1];
  logic           sq_ge     [0:RTW-1];
  logic [SRW-1:0] sq_rem_n  [0:RTW-1];
  logic [RTW-1:0] sq_root_n [0:RTW-1];

  for (genvar gt = 0; gt < RTW; gt++) begin : g_root
    localparam int J = RTW - 1 - gt;
    assign sq_acc[gt]    = {sq_rem[gt][SRW-3:0], sq_side[gt].sum[2*J+1 -: 2]};
    assign sq_trial[gt]  = {(SRW-2)'(sq_root[gt]), 2'b01};
    assign sq_ge[gt]     = sq_acc[gt] >= sq_trial[gt];
    assign sq_rem_n[gt]  = sq_ge[gt] ? sq_acc[gt] - sq_trial[gt] : sq_acc[gt];
    assign sq_root_n[gt] = {sq_root[gt][RTW-2:0], sq_ge[gt]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side[0].center <= r2_center;
      sq_side[0].copl   <= r2_copl;
      sq_side[0].close  <= r2_close;
      sq_side[0].csat   <= r2_csat;
      sq_side[0].radsat <= r2_radsat;
      sq_side[0].sum    <= SW'(r2_sq[0]) + SW'(r2_sq[1]) + SW'(r2_sq[2]);
      sq_rem[0]         <= '0;
      sq_root[0]        <= '0;
      for (int t = 0; t < RTW; t++) begin
        sq_rem[t+1]  <= sq_rem_n[t];
        sq_root[t+1] <= sq_root_n[t];
        sq_side[t+1] <= sq_side[t];
      end
    end
  end

  // Output stage: the root rounds up when the remainder exceeds the root.
  logic [RTW:0] rad_d;
  logic         rsat_d;
  root_side_t   fin;

  assign fin    = sq_side[RTW];
  assign rad_d  = (RTW+1)'(sq_root[RTW]) + (RTW+1)'(sq_rem[RTW] > SRW'(sq_root[RTW]));
  assign rsat_d = fin.radsat || (rad_d[RTW:CW] != '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.copl) begin
        center_x   <= '0;
        center_y   <= '0;
        center_z   <= '0;
        radius     <= '0;
        fit_status <= FIT_COPLANAR;
      end else if (fin.close) begin
        center_x   <= '0;
        center_y   <= '0;
        center_z   <= '0;
        radius     <= '0;
        fit_status <= FIT_TOO_CLOSE;
      end else begin
        center_x   <= fin.center[0];
        center_y   <= fin.center[1];
        center_z   <= fin.center[2];
        radius     <= rsat_d ? '1 : rad_d[CW-1:0];
        fit_status <= (fin.csat || rsat_d) ? FIT_SATURATED : FIT_OK;
      end
    end
  end

  // Nothing comes out of the pipeline in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A rejected fit carries an all-zero sphere.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && (fit_status == FIT_COPLANAR || fit_status == FIT_TOO_CLOSE)
      |-> radius == '0 && center_x == '0 && center_y == '0 && center_z == '0)
    else $error("rejected fit with nonzero sphere");

  // Without overflow the first divider ends with a remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
      vld[7+QW] && !dv_side[QW].copl && !dv_side[QW].ovf[0]
      |-> dv_rem[QW][0] < RW'(dv_side[QW].den))
    else $error("divider remainder out of range");

  // The root remainder never exceeds twice the root.
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
      vld[LAT-2] |-> sq_rem[RTW] <= SRW'({sq_root[RTW], 1'b0}))
    else $error("square root remainder out of range");

endmodule

[dv/tb.sv]
// Self-checking testbench for sphere_from_four_points: random and directed point quadruples.
// Depends on sfp_pkg and the block RTL; holds its own exact-integer sphere predictor.
`timescale 1ns / 1ps

module tb;
  import sfp_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef wide_t mat_t[9];
  typedef logic [3:0][2:0][CW-1:0] quad_t;

  typedef struct {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [CW-1:0]        rad;
    fit_status_t          status;
  } sphere_t;

  class sphere_scoreboard;
    sphere_t pending[$];
    logic [MPDW-1:0] min_dist;
    int errors;

    function new();
      min_dist = '0;
      errors = 0;
    endfunction

    function wide_t det3(mat_t m);
      wide_t t0, t1, t2;
      t0 = m[4] * m[8] - m[5] * m[7];
      t1 = m[3] * m[8] - m[5] * m[6];
      t2 = m[3] * m[7] - m[4] * m[6];
      return m[0] * t0 - m[1] * t1 + m[2] * t2;
    endfunction

    // Round to nearest with ties away from zero; magnitude clamped to 2^62.
    function wide_t round_div(wide_t n, wide_t d);
      logic [255:0] nm, dm, qm, rm;
      nm = n < 0 ? -n : n;
      dm = d < 0 ? -d : d;
      qm = nm / dm;
      rm = nm % dm;
      if (2 * rm >= dm) qm = qm + 1;
      if (qm >= (256'd1 << 62)) qm = 256'd1 << 62;
      return ((n < 0) != (d < 0)) ? -$signed(qm) : $signed(qm);
    endfunction

    function sphere_t fit(quad_t pt);
      sphere_t r;
      wide_t p[4][3];
      mat_t m, mk;
      wide_t h[3], qv[3], cen[3];
      wide_t det, den, tsq, d2, s, root, rad, cmax, cmin;
      bit closer;
      r = '{cx: '0, cy: '0, cz: '0, rad: '0, status: FIT_OK};
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 3; j++) p[i][j] = wide_t'($signed(pt[i][j]));
      for (int i = 0; i < 3; i++) begin
        h[i] = 0;
        for (int j = 0; j < 3; j++) begin
          m[i*3+j] = p[i+1][j] - p[0][j];
          h[i] = h[i] + m[i*3+j] * m[i*3+j];
        end
      end
      det = det3(m);
      if (det == 0) begin
        r.status = FIT_COPLANAR;
        return r;
      end
      tsq = wide_t'(min_dist) * wide_t'(min_dist);
      closer = 0;
      for (int i = 0; i < 4; i++)
        for (int j = i + 1; j < 4; j++) begin
          d2 = 0;
          for (int k = 0; k < 3; k++) d2 = d2 + (p[i][k] - p[j][k]) * (p[i][k] - p[j][k]);
          if (d2 < tsq) closer = 1;
        end
      if (closer) begin
        r.status = FIT_TOO_CLOSE;
        return r;
      end
      // The one-half of the scheme is folded into a doubled denominator.
      den = 2 * det;
      for (int k = 0; k < 3; k++) begin
        mk = m;
        for (int i = 0; i < 3; i++) mk[i*3+k] = h[i];
        qv[k] = round_div(det3(mk), den);
      end
      cmax = (wide_t'(1) <<< (CW - 1)) - 1;
      cmin = -cmax - 1;
      for (int k = 0; k < 3; k++) begin
        cen[k] = p[0][k] + qv[k];
        if (cen[k] > cmax) begin
          cen[k] = cmax;
          r.status = FIT_SATURATED;
        end
        if (cen[k] < cmin) begin
          cen[k] = cmin;
          r.status = FIT_SATURATED;
        end
      end
      r.cx = cen[0][CW-1:0];
      r.cy = cen[1][CW-1:0];
      r.cz = cen[2][CW-1:0];
      rad = 0;
      for (int k = 0; k < 3; k++)
        if (qv[k] >= (wide_t'(1) <<< CW) || qv[k] <= -(wide_t'(1) <<< CW))
          rad = wide_t'(1) <<< CW;
      if (rad == 0) begin
        s = qv[0] * qv[0] + qv[1] * qv[1] + qv[2] * qv[2];
        root = 0;
        for (int b = 40; b >= 0; b--)
          if ((root | (wide_t'(1) <<< b)) * (root | (wide_t'(1) <<< b)) <= s)
            root = root | (wide_t'(1) <<< b);
        if (s > root * root + root) root = root + 1;
        rad = root;
      end
      if (rad > (wide_t'(1) <<< CW) - 1) begin
        rad = (wide_t'(1) <<< CW) - 1;
        r.status = FIT_SATURATED;
      end
      r.rad = rad[CW-1:0];
      return r;
    endfunction

    function void note(quad_t pt);
      pending.insert(pending.size(), fit(pt));
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check(sphere_t got);
      sphere_t want;
      if (pending.size() == 0) begin
        report("result with no request waiting");
        return;
      end
      want = pending.pop_front();
      if (got.cx != want.cx) report($sformatf("center_x %h, want %h", got.cx, want.cx));
      if (got.cy != want.cy) report($sformatf("center_y %h, want %h", got.cy, want.cy));
      if (got.cz != want.cz) report($sformatf("center_z %h, want %h", got.cz, want.cz));
      if (got.rad != want.rad) report($sformatf("radius %h, want %h", got.rad, want.rad));
      if (got.status != want.status)
        report($sformatf("fit_status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  quad_t quad = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [CW-1:0] center_x, center_y, center_z;
  logic [CW-1:0] radius;
  logic [1:0] fit_status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [MPDW-1:0] min_pair_distance = '0;

  sphere_scoreboard sb = new();
  int req_count = 0;
  int cfg_count = 0;
  int idle_in = 0;
  int idle_out = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sphere_from_four_points i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_a_x(quad[0][0]), .point_a_y(quad[0][1]), .point_a_z(quad[0][2]),
    .point_b_x(quad[1][0]), .point_b_y(quad[1][1]), .point_b_z(quad[1][2]),
    .point_c_x(quad[2][0]), .point_c_y(quad[2][1]), .point_c_z(quad[2][2]),
    .point_d_x(quad[3][0]), .point_d_y(quad[3][1]), .point_d_z(quad[3][2]),
    .out_valid(out_valid), .out_ready(out_ready),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .radius(radius), .fit_status(fit_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .min_pair_distance(min_pair_distance)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note(quad);
        req_count++;
      end
      if (out_valid && out_ready)
        sb.check('{cx: center_x, cy: center_y, cz: center_z, rad: radius,
                   status: fit_status_t'(fit_status)});
      if (cfg_valid && cfg_ready) begin
        sb.min_dist = min_pair_distance;
        cfg_count++;
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= idle_out);

  task send_quad(quad_t pt);
    int seen;
    while ($urandom_range(99) < idle_in) begin
      in_valid = 0;
      @(negedge clk);
    end
    quad = pt;
    in_valid = 1;
    seen = req_count;
    do @(negedge clk); while (req_count == seen);
    in_valid = 0;
  endtask

  task write_min_dist(logic [MPDW-1:0] value);
    int seen;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT + 5) @(negedge clk);
    min_pair_distance = value;
    cfg_valid = 1;
    seen = cfg_count;
    do @(negedge clk); while (cfg_count == seen);
    cfg_valid = 0;
  endtask

  function logic [CW-1:0] pick_extreme();
    case ($urandom_range(5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return '0;
      3: return '1;
      4: return CW'(1);
      default: return $urandom;
    endcase
  endfunction

  function logic [CW-1:0] pick_small();
    return $unsigned($signed($urandom) >>> ($urandom_range(18, 10)));
  endfunction

  function quad_t random_quad();
    quad_t pt;
    int kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++)
        pt[i][j] = (kind < 15) ? $urandom : (kind < 25) ? pick_extreme() : pick_small();
    // Degenerate shapes: repeated point, collinear, coplanar, one point nearly on another.
    if (kind >= 70 && kind < 76) pt[$urandom_range(3, 1)] = pt[0];
    else if (kind >= 76 && kind < 82)
      for (int j = 0; j < 3; j++) pt[2][j] = 2 * pt[1][j] - pt[0][j];
    else if (kind >= 82 && kind < 88)
      for (int j = 0; j < 3; j++) pt[3][j] = pt[1][j] + pt[2][j] - pt[0][j];
    else if (kind >= 88 && kind < 94)
      for (int j = 0; j < 3; j++) pt[3][j] = pt[0][j] + CW'($signed(pick_small()) >>> 6);
    return pt;
  endfunction

  function quad_t make_quad(int ax, int ay, int az, int bx, int by, int bz,
                            int cx, int cy, int cz, int dx, int dy, int dz);
    quad_t pt;
    pt[0][0] = ax; pt[0][1] = ay; pt[0][2] = az;
    pt[1][0] = bx; pt[1][1] = by; pt[1][2] = bz;
    pt[2][0] = cx; pt[2][1] = cy; pt[2][2] = cz;
    pt[3][0] = dx; pt[3][1] = dy; pt[3][2] = dz;
    return pt;
  endfunction

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    quad_t pt;
    logic [MPDW-1:0] settings[6];
    int one, mx, mn;
    one = 1 << 16;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    settings[0] = '0;
    settings[1] = {MPDW{1'b1}};
    settings[2] = MPDW'(one);
    settings[3] = MPDW'($urandom_range(1 << 22));
    settings[4] = MPDW'($urandom);
    settings[5] = MPDW'($urandom_range(1 << 18));
    repeat (2) @(negedge clk);
    rst = 0;

    // Directed: unit sphere, all-zero and collinear sets, saturating and extreme corners.
    send_quad(make_quad(one, 0, 0, -one, 0, 0, 0, one, 0, 0, 0, one));
    send_quad(make_quad(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one));
    send_quad(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_quad(make_quad(0, 0, 0, one, one, one, 2 * one, 2 * one, 2 * one, 0, one, 0));
    send_quad(make_quad(0, 0, 0, one, 0, 0, 0, one, 0, one, one, 0));
    send_quad(make_quad(0, 0, 0, 1, 0, 0, 0, 1, 0, mx, mx, 1));
    send_quad(make_quad(mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mn));
    send_quad(make_quad(mn, mn, mn, mx, mn, mn, mn, mx, mn, mn, mn, mx));
    send_quad(make_quad(mx, mx, mx, mx - 1, mx, mx, mx, mx - 1, mx, mx, mx, mx - 1));
    send_quad(make_quad(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_quad(make_quad(-1, -1, -1, 1, 2, 3, -5, 7, 11, 13, -17, 19));
    write_min_dist(MPDW'(one));
    send_quad(make_quad(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one));
    send_quad(make_quad(0, 0, 0, one - 1, 0, 0, 0, one, 0, 0, 0, one));
    send_quad(make_quad(0, 0, 0, one, 0, 0, one, 0, 0, 0, 0, one));
    write_min_dist({MPDW{1'b1}});
    send_quad(make_quad(mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mn));
    send_quad(make_quad(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one));

    for (int phase = 0; phase < 6; phase++) begin
      write_min_dist(settings[phase]);
      case (phase / 2)
        0: begin idle_in = 27; idle_out = 61; end
        1: begin idle_in = 61; idle_out = 27; end
        default: begin idle_in = 0; idle_out = 0; end
      endcase
      for (int n = 0; n < 165; n++) begin
        pt = random_quad();
        send_quad(pt);
      end
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
